// File: hw/rtl/brlp_pkg.sv
// shared constants, types and codes for the request line parser
package brlp_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_FORMAT  = 3'd1;
  localparam logic [2:0] ST_BAD_DIGIT   = 3'd2;
  localparam logic [2:0] ST_SRC_NOT_DEC = 3'd3;
  localparam logic [2:0] ST_TGT_NOT_DEC = 3'd4;
  localparam logic [2:0] ST_SRC_RANGE   = 3'd5;
  localparam logic [2:0] ST_TGT_RANGE   = 3'd6;
  localparam logic [2:0] ST_DIGIT_BIG   = 3'd7;

  // field phase codes
  localparam logic [1:0] PH_NUMBER = 2'd0;
  localparam logic [1:0] PH_SOURCE = 2'd1;
  localparam logic [1:0] PH_TARGET = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [5:0] DIGIT_NONE = 6'd62;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_MAX   = 6'd62;
  localparam logic [5:0] ACC_SAT    = 6'd63;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VTAB  = 8'h0b;

  typedef struct packed {
    logic [5:0] digit;     // 0..61, DIGIT_NONE when not a digit
    logic       is_dec;
    logic       is_space;
    logic       is_ws;
  } char_class_t;

endpackage

// File: hw/rtl/brlp_decode.sv
// character classifier: digit value and whitespace flags of one byte
module brlp_decode
  import brlp_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t cls
);

  logic [7:0] diff;

  always_comb begin
    diff = 8'd0;
    cls.digit = DIGIT_NONE;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      diff = char_code - 8'h30;
      cls.digit = diff[5:0];
    end else if (char_code >= 8'h61 && char_code <= 8'h7a) begin
      diff = char_code - 8'h61 + 8'd10;
      cls.digit = diff[5:0];
    end else if (char_code >= 8'h41 && char_code <= 8'h5a) begin
      diff = char_code - 8'h41 + 8'd36;
      cls.digit = diff[5:0];
    end
    cls.is_dec   = (char_code >= 8'h30 && char_code <= 8'h39);
    cls.is_space = (char_code == CH_SPACE);
    cls.is_ws    = (char_code == CH_NL) || (char_code == CH_TAB) || (char_code == CH_VTAB);
  end

endmodule

// File: hw/rtl/brlp_core.sv
// line state update, end-of-line checks and result register
module brlp_core
  import brlp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,       // held byte moves on this cycle
  input  logic                   last,
  input  char_class_t            cls,
  input  logic                   advance,    // result register may load
  output logic                   res_valid,
  output logic [2:0]             res_status,
  output logic [LENGTH_BITS-1:0] res_length,
  output logic [5:0]             res_source,
  output logic [5:0]             res_target
);

  logic [1:0]             field_phase, field_phase_next;
  logic [2:0]             latched_error, latched_error_next;
  logic [5:0]             highest_digit, highest_digit_next;
  logic [LENGTH_BITS-1:0] digit_count, digit_count_next;
  logic [5:0]             source_accum, source_accum_next;
  logic [5:0]             target_accum, target_accum_next;
  logic                   source_seen, source_seen_next;
  logic                   target_seen, target_seen_next;
  logic [9:0]             acc_in, acc_sum;
  logic [5:0]             acc_sat;
  logic [2:0]             status_next;

  // shared decimal accumulator, saturating at 63
  always_comb begin
    acc_in  = (field_phase == PH_SOURCE) ? {4'd0, source_accum} : {4'd0, target_accum};
    acc_sum = acc_in * 10'd10 + {4'd0, cls.digit};
    acc_sat = (acc_sum > 10'd63) ? ACC_SAT : acc_sum[5:0];
  end

  always_comb begin
    field_phase_next   = field_phase;
    latched_error_next = latched_error;
    highest_digit_next = highest_digit;
    digit_count_next   = digit_count;
    source_accum_next  = source_accum;
    target_accum_next  = target_accum;
    source_seen_next   = source_seen;
    target_seen_next   = target_seen;
    if (latched_error == ST_OK && field_phase != PH_DONE) begin
      unique case (field_phase)
        PH_NUMBER: begin
          if (cls.is_space) field_phase_next = PH_SOURCE;
          else if (cls.is_ws) latched_error_next = ST_BAD_FORMAT;
          else if (cls.digit >= DIGIT_NONE) latched_error_next = ST_BAD_DIGIT;
          else begin
            if (cls.digit > highest_digit) highest_digit_next = cls.digit;
            if (digit_count != '1) digit_count_next = digit_count + 1'b1;
          end
        end
        PH_SOURCE: begin
          if (cls.is_space) field_phase_next = PH_TARGET;
          else if (cls.is_ws) latched_error_next = ST_BAD_FORMAT;
          else if (!cls.is_dec) latched_error_next = ST_SRC_NOT_DEC;
          else begin
            source_accum_next = acc_sat;
            source_seen_next  = 1'b1;
          end
        end
        PH_TARGET: begin
          if (cls.is_space || cls.is_ws) field_phase_next = PH_DONE;
          else if (!cls.is_dec) latched_error_next = ST_TGT_NOT_DEC;
          else begin
            target_accum_next = acc_sat;
            target_seen_next  = 1'b1;
          end
        end
        default: field_phase_next = field_phase;
      endcase
    end

    if (latched_error_next != ST_OK) status_next = latched_error_next;
    else if (digit_count_next == '0 || !source_seen_next || !target_seen_next)
      status_next = ST_BAD_FORMAT;
    else if (source_accum_next < BASE_MIN || source_accum_next > BASE_MAX)
      status_next = ST_SRC_RANGE;
    else if (target_accum_next < BASE_MIN || target_accum_next > BASE_MAX)
      status_next = ST_TGT_RANGE;
    else if (highest_digit_next >= source_accum_next) status_next = ST_DIGIT_BIG;
    else status_next = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      field_phase   <= PH_NUMBER;
      latched_error <= ST_OK;
      highest_digit <= '0;
      digit_count   <= '0;
      source_accum  <= '0;
      target_accum  <= '0;
      source_seen   <= 1'b0;
      target_seen   <= 1'b0;
    end else if (step) begin
      field_phase   <= field_phase_next;
      latched_error <= latched_error_next;
      highest_digit <= highest_digit_next;
      digit_count   <= digit_count_next;
      source_accum  <= source_accum_next;
      target_accum  <= target_accum_next;
      source_seen   <= source_seen_next;
      target_seen   <= target_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step && last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last) begin
      res_status <= status_next;
      res_length <= digit_count_next;
      res_source <= source_accum_next;
      res_target <= target_accum_next;
    end
  end

endmodule

// File: hw/rtl/base_request_line_parser.sv
// top level of the request line parser: input register, classifier, line state
//
// Takes one byte of a request line "<number> <source base> <target base>"
// per transfer on the input channel (char_code, is_last with in_valid and
// in_ready). The byte flagged is_last closes the line and yields exactly one
// result on the output channel (status, number_length, source_base,
// target_base with out_valid and out_ready); other bytes yield none.
// A last byte passes the input register and then the result register before
// its result shows. Throughput: one byte per cycle while the receiver does
// not stall, set by the combinational state update between the two registers.
// When the receiver stalls, the result holds and the input register takes
// one more byte if it is empty; then in_ready drops until the result is taken.
// Reset clears both valid flags and the line state to the number field.
// After each result the line state returns to its reset values.
module base_request_line_parser
  import brlp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             char_code,
  input  logic                   is_last,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic [2:0]             status,
  output logic [LENGTH_BITS-1:0] number_length,
  output logic [5:0]             source_base,
  output logic [5:0]             target_base,
  output logic                   out_valid,
  input  logic                   out_ready
);

  logic        held_valid;
  logic [7:0]  held_char;
  logic        held_last;
  logic        advance;
  char_class_t cls;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_char <= char_code;
      held_last <= is_last;
    end
  end

  brlp_decode u_decode (
    .char_code (held_char),
    .cls       (cls)
  );

  brlp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (held_valid && advance),
    .last       (held_last),
    .cls        (cls),
    .advance    (advance),
    .res_valid  (out_valid),
    .res_status (status),
    .res_length (number_length),
    .res_source (source_base),
    .res_target (target_base)
  );

endmodule

// File: hw/rtl/brlp_checker.sv
// port-level checker for the request line parser, bound to the top level
module brlp_checker
  import brlp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [2:0]             status,
  input logic [LENGTH_BITS-1:0] number_length,
  input logic [5:0]             source_base,
  input logic [5:0]             target_base
);

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(number_length)
      && $stable(source_base) && $stable(target_base))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // with no result waiting the input side never blocks
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no result waiting");

  // an ok line has both bases in range and a nonempty number
  a_ok_bases: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> source_base >= BASE_MIN && source_base <= BASE_MAX
      && target_base >= BASE_MIN && target_base <= BASE_MAX && number_length != '0)
    else $error("ok status with bad fields");

  // a range error is only reported once the number field was nonempty
  a_range_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_SRC_RANGE || status == ST_TGT_RANGE || status == ST_DIGIT_BIG)
      |-> number_length != '0)
    else $error("range status with empty number");

endmodule

bind base_request_line_parser brlp_checker #(
  .LENGTH_BITS (LENGTH_BITS)
) u_brlp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .number_length (number_length),
  .source_base   (source_base),
  .target_base   (target_base)
);
